### hw/rtl/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// shared constants and sequencer state type for the max heap builder
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;   // width of the value field on both streams
  localparam int EXT_W          = 64;   // width that input values are sign-extended to

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_NODE,
    ST_RDP,
    ST_RDL,
    ST_RDR,
    ST_CMP,
    ST_SWP2,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

### hw/rtl/bmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bmh_ram #(
  parameter int WIDTH = bmh_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = bmh_pkg::MAX_ITEMS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/build_max_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// build_max_heap
// collects signed values, builds a max heap bottom-up by sift-down and
// streams the heap out in position order
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+-------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: value, tlast: last of array
//  m_*      | out       | m_tvalid/m_tready  | tdata: value_res, tlast: last_res,
//           |           |                    | tuser: dropped
//
//  loading takes one request per cycle; a request beyond MAX_ITEMS is dropped
//  and flagged on every result of that array
//  after the last request each node from the last parent down to the root is
//  sifted down level by level, all through one shared comparator and the
//  single read port of the heap ram
//  emission reads each result and loads it into the output register once it is
//  free; the last result may wait there while the next array loads
//  rst is synchronous and clears the sequencer, the count, the overflow flag
//  and the output valid; the ram needs no clearing since only written entries
//  are read
//
module build_max_heap #(
  parameter int MAX_ITEMS  = bmh_pkg::MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = bmh_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bmh_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic                       s_tlast,    // last element of the array
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bmh_pkg::VALUE_W-1:0] m_tdata,   // [31:0] value_res
  output logic                       m_tlast,    // last_res
  output logic                       m_tuser     // [0] dropped
);

  import bmh_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t state, state_next;

  // element count and overflow flag of the array being collected
  logic [CNT_W-1:0]      cnt;
  logic                  ovf;
  // build loop: current node, sift position, winner of the compares
  logic [CNT_W-1:0]      node;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W:0]        big_pos;
  logic [DATA_WIDTH-1:0] par_val;
  logic [DATA_WIDTH-1:0] big_val;
  logic [CNT_W-1:0]      eidx;

  // heap ram port signals
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] rd_data;

  // request side
  logic                  s_acc;
  logic                  store_ok;
  logic [CNT_W-1:0]      cnt_new;
  logic [EXT_W-1:0]      in_ext;

  // tree arithmetic
  logic [CNT_W-1:0]      pos_m1;
  logic [CNT_W:0]        cnt_x;
  logic [CNT_W:0]        left;
  logic [CNT_W:0]        right;
  logic [CNT_W:0]        left_m1;
  logic [CNT_W:0]        right_m1;
  logic [CNT_W:0]        bleft_m1;
  logic [CNT_W:0]        big_m1;
  logic                  left_ok;
  logic                  right_ok;

  // shared comparator
  logic [DATA_WIDTH-1:0] cmp_a;
  logic                  cmp_lt;
  logic [CNT_W:0]        fin_pos;
  logic [DATA_WIDTH-1:0] fin_val;
  logic                  sift_done;

  // emission
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  emit_last;
  logic [EXT_W+DATA_WIDTH-1:0] out_ext;

  assign s_tready = (state == ST_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign store_ok = (cnt < CNT_W'(MAX_ITEMS));
  assign cnt_new  = store_ok ? cnt + CNT_W'(1) : cnt;
  assign in_ext   = {{(EXT_W - VALUE_W){s_tdata[VALUE_W-1]}}, s_tdata};

  assign pos_m1   = pos - CNT_W'(1);
  assign cnt_x    = {1'b0, cnt};
  assign left     = {pos, 1'b0};
  assign right    = {pos, 1'b1};
  assign left_m1  = left - (CNT_W+1)'(1);
  assign right_m1 = {1'b0, left[CNT_W-1:0]};      // right - 1 equals left
  assign bleft_m1 = {big_pos[CNT_W-1:0], 1'b0} - (CNT_W+1)'(1);
  assign big_m1   = big_pos - (CNT_W+1)'(1);
  assign left_ok  = (left <= cnt_x);
  assign right_ok = (right <= cnt_x);

  // one signed less-than, parent against left child, then winner against right
  assign cmp_a     = (state == ST_CMP) ? big_val : par_val;
  assign cmp_lt    = ($signed(cmp_a) < $signed(rd_data));
  assign fin_pos   = (right_ok && cmp_lt) ? right : big_pos;
  assign fin_val   = (right_ok && cmp_lt) ? rd_data : big_val;
  assign sift_done = (fin_pos == {1'b0, pos});

  assign out_free  = !m_tvalid || m_tready;
  assign cnt_m1    = cnt - CNT_W'(1);
  assign emit_last = (eidx == cnt_m1);
  assign out_ext   = {{EXT_W{rd_data[DATA_WIDTH-1]}}, rd_data};

  bmh_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ITEMS),
    .AW    (IDX_W)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and ram port control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt[IDX_W-1:0];
    ram_wdata  = in_ext[DATA_WIDTH-1:0];
    ram_raddr  = pos_m1[IDX_W-1:0];
    case (state)
      ST_LOAD: begin
        ram_we = s_acc && store_ok;
        if (s_acc && s_tlast) begin
          state_next = ST_NODE;
        end
      end
      ST_NODE: begin
        state_next = (node == '0) ? ST_EMIT_RD : ST_RDP;
      end
      ST_RDP: begin
        state_next = ST_RDL;
      end
      ST_RDL: begin
        ram_raddr  = left_m1[IDX_W-1:0];
        state_next = ST_RDR;
      end
      ST_RDR: begin
        ram_raddr  = right_m1[IDX_W-1:0];
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sift_done) begin
          state_next = ST_NODE;
        end else begin
          // winner moves up into the parent slot
          ram_we     = 1'b1;
          ram_waddr  = pos_m1[IDX_W-1:0];
          ram_wdata  = fin_val;
          state_next = ST_SWP2;
        end
      end
      ST_SWP2: begin
        // parent drops into the winner slot, fetch its new left child
        ram_we     = 1'b1;
        ram_waddr  = big_m1[IDX_W-1:0];
        ram_wdata  = par_val;
        ram_raddr  = bleft_m1[IDX_W-1:0];
        state_next = ST_RDR;
      end
      ST_EMIT_RD: begin
        ram_raddr = eidx[IDX_W-1:0];
        if (out_free) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT_LD) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (s_acc) begin
            cnt  <= cnt_new;
            ovf  <= ovf | !store_ok;
            node <= cnt_new >> 1;
            eidx <= '0;
          end
        end
        ST_NODE: begin
          pos <= node;
        end
        ST_RDL: begin
          par_val <= rd_data;
        end
        ST_RDR: begin
          if (left_ok && cmp_lt) begin
            big_val <= rd_data;
            big_pos <= left;
          end else begin
            big_val <= par_val;
            big_pos <= {1'b0, pos};
          end
        end
        ST_CMP: begin
          big_pos <= fin_pos;
          if (sift_done) begin
            node <= node - CNT_W'(1);
          end
        end
        ST_SWP2: begin
          pos <= big_pos[CNT_W-1:0];
        end
        ST_EMIT_LD: begin
          m_tdata <= out_ext[VALUE_W-1:0];
          m_tlast <= emit_last;
          m_tuser <= ovf;
          if (emit_last) begin
            cnt <= '0;
            ovf <= 1'b0;
          end else begin
            eidx <= eidx + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a stored request never lands beyond the heap
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == ST_LOAD) |-> cnt < CNT_W'(MAX_ITEMS))
    else $error("heap write beyond capacity");

  // sift position stays inside the heap
  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDP || state == ST_RDL || state == ST_RDR || state == ST_CMP)
    |-> (pos != '0) && (pos <= cnt))
    else $error("sift position outside the heap");

  // a swap always moves the node down to a child
  a_swap_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) && !sift_done |-> fin_pos > {1'b0, pos})
    else $error("swap does not move down");

  // results are only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD) |-> !m_tvalid)
    else $error("output register overwritten");

  // after the last result the block is cleared for the next array
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD) && emit_last |=> (state == ST_LOAD) && (cnt == '0) && !ovf)
    else $error("block not cleared after last result");
`endif

endmodule
